// ----- hw/rtl/ckl_pkg.sv -----
// Shared types and helpers for the compacted key list.
// Holds the payload structs, status and operation codes, controller states,
// the control interface structs and the key normalization function.
`default_nettype none

package ckl_pkg;

  localparam int unsigned KeyBytes = 24;
  localparam int unsigned KeyWidth = 8 * KeyBytes;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
  } ckl_req_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] item_count;
  } ckl_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_WAIT,
    S_FINISH,
    S_RESP
  } ckl_state_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic rd_en;
    logic finish;
  } ckl_cmd_t;

  typedef struct packed {
    logic key_empty;
    logic is_remove;
    logic count_zero;
    logic last_issue;
  } ckl_stat_t;

  // Clears every byte from the first zero byte on. The key is laid out with
  // byte 0 in the low bits.
  function automatic logic [KeyWidth-1:0] ckl_normalize(input logic [KeyWidth-1:0] key);
    logic [KeyBytes-1:0] zero;
    logic [KeyBytes-1:0] mask;
    logic [KeyWidth-1:0] r;
    for (int b = 0; b < KeyBytes; b++) begin
      zero[b] = (key[8*b +: 8] == 8'd0);
    end
    for (int b = 0; b < KeyBytes; b++) begin
      mask = (KeyBytes'(1) << (b + 1)) - KeyBytes'(1);
      r[8*b +: 8] = (|(zero & mask)) ? 8'd0 : key[8*b +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ckl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the key slot storage.
`default_nettype none

module ckl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ckl_datapath.sv -----
// Datapath of the compacted key list: key register, count, slot memory,
// scan address counter, compare and shift logic. Depends on ckl_pkg, ckl_ram.
`default_nettype none

module ckl_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ckl_pkg::ckl_req_t req_i,
  input  wire ckl_pkg::ckl_cmd_t cmd_i,
  output ckl_pkg::ckl_stat_t     stat_o,
  output ckl_pkg::ckl_res_t      res_o
);
  import ckl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KeyWidth-1:0] key_q;
  op_e                 op_q;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       raddr_q;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_idx_q;
  logic                found_q, found_d;
  ckl_res_t            res_q, res_d;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [KeyWidth-1:0] wdata;
  logic [KeyWidth-1:0] rdata;
  logic                full;
  logic                key_empty;
  logic                insert_ok;

  assign full      = (count_q == CW'(CAPACITY));
  assign key_empty = (key_q[7:0] == 8'd0);
  assign insert_ok = cmd_i.decide && !key_empty && (op_q == OP_INSERT) && !full;

  assign stat_o.key_empty  = key_empty;
  assign stat_o.is_remove  = (op_q == OP_REMOVE);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.last_issue = (CW'(raddr_q) == count_q - CW'(1));

  ckl_ram #(
    .WIDTH(KeyWidth),
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = key_q;
    if (insert_ok) begin
      we = 1'b1;
    end else if (rd_vld_q && found_q) begin
      we    = 1'b1;
      waddr = rd_idx_q - AW'(1);
      wdata = rdata;
    end
  end

  always_comb begin
    found_d = found_q;
    if (cmd_i.load) begin
      found_d = 1'b0;
    end else if (rd_vld_q && !found_q && (rdata == key_q)) begin
      found_d = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    res_d   = res_q;
    if (cmd_i.decide) begin
      res_d.status = ST_OK;
      if (key_empty) begin
        if (full) begin
          res_d.status = (op_q == OP_REMOVE) ? ST_NOT_FOUND : ST_FULL;
        end
      end else if (op_q == OP_INSERT) begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end else if (count_q == '0) begin
        res_d.status = ST_NOT_FOUND;
      end
      res_d.item_count = 5'(count_d);
    end else if (cmd_i.finish) begin
      if (found_q) begin
        res_d.status = ST_OK;
        count_d      = count_q - CW'(1);
      end else begin
        res_d.status = ST_NOT_FOUND;
      end
      res_d.item_count = 5'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      found_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      raddr_q  <= '0;
    end else begin
      count_q  <= count_d;
      found_q  <= found_d;
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        raddr_q <= '0;
      end else if (cmd_i.rd_en) begin
        raddr_q <= raddr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= ckl_normalize({req_i.key_word2, req_i.key_word1, req_i.key_word0});
      op_q  <= req_i.op;
    end
    rd_idx_q <= raddr_q;
    res_q    <= res_d;
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_shift_not_slot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && found_q) |-> (rd_idx_q != '0))
    else $error("shift write would target below slot zero");

  a_remove_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && found_q) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("successful remove did not shrink the list");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert_ok |=> (count_q == $past(count_q) + CW'(1)))
    else $error("successful insert did not grow the list");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ckl_ctrl.sv -----
// Controller state machine of the compacted key list.
// Sequences load, decision, slot scan and result; depends on ckl_pkg.
`default_nettype none

module ckl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    result_valid_o,
  input  wire ckl_pkg::ckl_stat_t stat_i,
  output ckl_pkg::ckl_cmd_t       cmd_o
);
  import ckl_pkg::*;

  ckl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = (state_q != S_IDLE);
    result_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (!stat_i.key_empty && stat_i.is_remove && !stat_i.count_zero) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.last_issue) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        result_valid_o = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/compacted_key_list_core.sv -----
// Top level of the compacted key list: a packed list of up to CAPACITY keys.
// Joins ckl_ctrl and ckl_datapath; depends on ckl_pkg.
//
// Usage: drive req_i and raise start; the item is taken at a rising edge with
// start high and busy low. Each item is an insert or a remove of one key of up
// to 24 bytes; bytes after the first zero byte are ignored. Exactly one result
// follows per item, on res_o for one cycle with result_valid_o high. The
// receiver cannot stall; the result must be captured in that cycle.
// From the accepting edge, an insert, an empty key, or a remove on an empty list
// goes through the decide state to the result state; a remove that scans goes
// through decide, scan, wait and finish to the result. busy drops in the cycle
// after the result. The scan reads the slot memory one slot per cycle and moves
// each later entry up one slot as it streams past the hit.
// Reset clears the count to zero and returns the controller to idle; slot
// contents are left as they are, since only slots below the count are read.
`default_nettype none

module compacted_key_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ckl_pkg::ckl_req_t req_i,
  output logic                   result_valid_o,
  output ckl_pkg::ckl_res_t      res_o
);
  import ckl_pkg::*;

  ckl_cmd_t  cmd;
  ckl_stat_t stat;

  ckl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  ckl_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (res_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_compacted_key_list_core.sv -----
// Self-checking testbench for compacted_key_list_core, the packed list of short text keys.
// A directed table and then random inserts and removes are scored against a local model.
// Depends on ckl_pkg for the request and result structs and their codes.
module tb_compacted_key_list_core;
  import ckl_pkg::*;

  localparam int Cap = 16;
  localparam int NumRows = 15;
  localparam int RandPerPhase = 440;

  typedef struct {
    op_e         op;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    int          reps;
    bit          typed;
    status_e     st;
    int          cnt;
  } step_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ckl_req_t req_i = '0;
  logic     result_valid_o;
  ckl_res_t res_o;

  logic [191:0] slot_key [Cap];
  int           key_count = 0;
  logic [191:0] key_pool [20];
  ckl_res_t     pending [$];
  int           errors = 0;
  int           sent = 0;
  int           checked = 0;
  int           full_seen = 0;
  int           miss_seen = 0;

  // Keys are written with the first character in the low byte.
  step_t plan [NumRows] = '{
    '{OP_REMOVE, 64'h41, 64'h0, 64'h0, 1, 1'b1, ST_NOT_FOUND, 0},
    '{OP_INSERT, 64'h0, 64'h0, 64'h0, 1, 1'b1, ST_OK, 0},
    '{OP_INSERT, '1, '1, '1, 1, 1'b1, ST_OK, 1},
    '{OP_INSERT, 64'h5A5A_5A5A_5A00_4241, 64'h1234_5678_9ABC_DEF0, '1, 1, 1'b1, ST_OK, 2},
    '{OP_INSERT, 64'h4241, 64'h0, 64'h0, 1, 1'b1, ST_OK, 3},
    '{OP_REMOVE, 64'h4241, 64'h0, 64'h0, 1, 1'b1, ST_OK, 2},
    '{OP_INSERT, 64'h4847_4645_4443_4241, 64'hA5A5_A5A5_A500_4A49, '1, 1, 1'b1, ST_OK, 3},
    '{OP_REMOVE, 64'h4847_4645_4443_4241, 64'h4A49, 64'h0, 1, 1'b1, ST_OK, 2},
    '{OP_REMOVE, 64'h7A7A, 64'h0, 64'h0, 1, 1'b1, ST_NOT_FOUND, 2},
    '{OP_INSERT, 64'h4B, 64'h0, 64'h0, 14, 1'b0, ST_OK, 0},
    '{OP_INSERT, 64'h51, 64'h0, 64'h0, 1, 1'b1, ST_FULL, 16},
    '{OP_INSERT, 64'h0, 64'h0, 64'h0, 1, 1'b1, ST_FULL, 16},
    '{OP_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, 1, 1'b1, ST_NOT_FOUND, 16},
    '{OP_REMOVE, '1, '1, '1, 1, 1'b1, ST_OK, 15},
    '{OP_REMOVE, 64'h0E4B, 64'h0, 64'h0, 1, 1'b1, ST_OK, 14}
  };

  compacted_key_list_core #(
    .CAPACITY(Cap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o)
  );

  always #2 clk_i = ~clk_i;

  // A key ends at its first zero byte; everything after it counts as zero.
  function automatic logic [191:0] trim_key(logic [191:0] k);
    logic [191:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < 24; b++) begin
      if (k[8*b +: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[8*b +: 8] = k[8*b +: 8];
    end
    return r;
  endfunction

  function automatic ckl_res_t apply_op(ckl_req_t r);
    logic [191:0] k;
    bit is_full;
    int hit;
    ckl_res_t res;
    k = trim_key({r.key_word2, r.key_word1, r.key_word0});
    is_full = (key_count == Cap);
    hit = -1;
    res.status = ST_OK;
    if (k[7:0] == 8'd0) begin
      if (is_full) res.status = (r.op == OP_REMOVE) ? ST_NOT_FOUND : ST_FULL;
    end else if (r.op == OP_INSERT) begin
      if (is_full) begin
        res.status = ST_FULL;
      end else begin
        slot_key[key_count] = k;
        key_count++;
      end
    end else begin
      for (int i = 0; i < key_count; i++) begin
        if (hit < 0 && slot_key[i] == k) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < key_count; i++) slot_key[i] = slot_key[i + 1];
        key_count--;
        slot_key[key_count] = '0;
      end
    end
    res.item_count = 5'(key_count);
    return res;
  endfunction

  function automatic logic [191:0] rand_key(int len);
    logic [191:0] k;
    k = '0;
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  // Fills the bytes after the terminator with garbage half of the time.
  function automatic logic [191:0] add_junk(logic [191:0] k);
    logic [191:0] r;
    bit ended;
    r = k;
    ended = 1'b0;
    if ($urandom_range(1) == 0) return r;
    for (int b = 0; b < 24; b++) begin
      if (ended) r[8*b +: 8] = 8'($urandom_range(255));
      if (k[8*b +: 8] == 8'd0) ended = 1'b1;
    end
    return r;
  endfunction

  task automatic issue(ckl_req_t req, int idle_pct, bit typed, status_e st, int cnt);
    ckl_res_t exp_res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    exp_res = apply_op(req);
    if (typed) begin
      exp_res.status = st;
      exp_res.item_count = 5'(cnt);
    end
    pending.push_back(exp_res);
    sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending.size() == 0) begin
        $error("result with no item outstanding: status %0d count %0d",
               res_o.status, res_o.item_count);
        errors++;
      end else begin
        if (res_o.status !== pending[0].status) begin
          $error("status: expected %0d, got %0d", pending[0].status, res_o.status);
          errors++;
        end
        if (res_o.item_count !== pending[0].item_count) begin
          $error("item_count: expected %0d, got %0d", pending[0].item_count, res_o.item_count);
          errors++;
        end
        if (pending[0].status == ST_FULL) full_seen++;
        if (pending[0].status == ST_NOT_FOUND) miss_seen++;
        void'(pending.pop_front());
        checked++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    ckl_req_t req;
    logic [191:0] k;
    int pick;
    int idle_pct;
    int directed;
    int guard;
    bit filling;
    for (int i = 0; i < Cap; i++) slot_key[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        req.op = plan[r].op;
        req.key_word0 = (plan[r].reps > 1) ? (plan[r].w0 | (64'(i + 1) << 8)) : plan[r].w0;
        req.key_word1 = plan[r].w1;
        req.key_word2 = plan[r].w2;
        issue(req, 0, plan[r].typed && plan[r].reps == 1, plan[r].st, plan[r].cnt);
      end
    end
    directed = sent;

    for (int i = 0; i < 20; i++) begin
      key_pool[i] = rand_key((i < 14) ? $urandom_range(8, 1) : $urandom_range(24, 9));
    end
    filling = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 80 : 11;
      for (int n = 0; n < RandPerPhase; n++) begin
        if (key_count == Cap) filling = 1'b0;
        if (key_count == 0) filling = 1'b1;
        req.op = ($urandom_range(99) < (filling ? 70 : 30)) ? OP_INSERT : OP_REMOVE;
        pick = $urandom_range(99);
        if (pick < 8) begin
          k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          k[7:0] = 8'd0;
        end else if (pick < 18) begin
          k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (req.op == OP_REMOVE && key_count > 0 && pick < 70) begin
          k = add_junk(slot_key[$urandom_range(key_count - 1)]);
        end else begin
          k = add_junk(key_pool[$urandom_range(19)]);
        end
        {req.key_word2, req.key_word1, req.key_word0} = k;
        issue(req, idle_pct, 1'b0, ST_OK, 0);
      end
    end
    start <= 1'b0;

    guard = 0;
    while (pending.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      errors++;
    end

    $display("Sent %0d items (%0d from the directed table), checked %0d results.",
             sent, directed, checked);
    $display("Saw %0d list-full and %0d not-found statuses across three idle settings.",
             full_seen, miss_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
